@@ sv/frlt_pkg.sv @@
// Shared types and constants for the feed resubscribe liveness table.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package frlt_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MIN_DELAY_MS = 1;
  localparam int DELAY_W      = 16;
  localparam int KEY_W        = 32;
  localparam int TIME_W       = 48;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

  typedef enum logic [2:0] {
    MODE_SUBSCRIBE   = 3'd0,
    MODE_UNSUBSCRIBE = 3'd1,
    MODE_RECONNECT   = 3'd2,
    MODE_TICK        = 3'd3,
    MODE_QUERY       = 3'd4,
    MODE_LIST_MUTE   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    PH_SUB   = 2'd0,
    PH_AWAIT = 2'd1,
    PH_LIVE  = 2'd2,
    PH_MUTE  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_ONE,
    ST_ACT,
    ST_LIST_SCAN,
    ST_DECIDE
  } ctl_state_e;

  typedef struct packed {
    logic capture;    // latch item, start a search pass
    logic scan_step;  // evaluate one entry, advance index
    logic act;        // apply single-token op, load result
    logic decide;     // close a list round
  } ctl_cmd_t;

  typedef struct packed {
    logic       scan_last;
    logic       cand_found;
    logic       pend_valid;
    logic       out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

@@ sv/frlt_ctrl.sv @@
// Controller FSM for the liveness table: sequences search passes and result loads.
// Depends on frlt_pkg.
`default_nettype none
module frlt_ctrl import frlt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic [2:0] in_mode_i,
  output logic          in_ready_o,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      cmd_o
);

  ctl_state_e state_q, state_d;
  logic       in_fire;
  logic       single_mode, list_mode;

  assign in_fire     = in_valid_i && (state_q == ST_IDLE);
  assign single_mode = (in_mode_i == MODE_SUBSCRIBE) || (in_mode_i == MODE_UNSUBSCRIBE) ||
                       (in_mode_i == MODE_TICK) || (in_mode_i == MODE_QUERY);
  assign list_mode   = (in_mode_i == MODE_RECONNECT) || (in_mode_i == MODE_LIST_MUTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (single_mode)    state_d = ST_SCAN_ONE;
          else if (list_mode) state_d = ST_LIST_SCAN;
          else                state_d = ST_ACT;
        end
      end
      ST_SCAN_ONE:  if (sts_i.scan_last) state_d = ST_ACT;
      ST_ACT:       if (sts_i.out_free) state_d = ST_IDLE;
      ST_LIST_SCAN: if (sts_i.scan_last) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if ((sts_i.cand_found && !sts_i.pend_valid) || sts_i.out_free) begin
          state_d = sts_i.cand_found ? ST_LIST_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_fire;
      end
      ST_SCAN_ONE, ST_LIST_SCAN: cmd_o.scan_step = 1'b1;
      ST_ACT:    cmd_o.act = sts_i.out_free;
      ST_DECIDE: cmd_o.decide = (sts_i.cand_found && !sts_i.pend_valid) || sts_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/frlt_dp.sv @@
// Datapath for the liveness table: entry store, scan logic, list state, output register.
// Depends on frlt_pkg; driven by frlt_ctrl commands.
`default_nettype none
module frlt_dp import frlt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctl_cmd_t          cmd_i,
  output ctl_sts_t               sts_o,
  input  wire logic [2:0]        in_mode_i,
  input  wire logic [KEY_W-1:0]  in_key_i,
  input  wire logic [TIME_W-1:0] in_now_i,
  input  wire logic              cfg_we_i,
  input  wire logic [DELAY_W-1:0] cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [KEY_W-1:0]       out_token_o,
  output logic [1:0]             out_state_o,
  output logic                   out_tradable_o,
  output logic                   out_found_o,
  output logic                   out_full_o,
  output logic                   out_last_o
);

  // entry store
  logic              valid_q [TABLE_DEPTH];
  logic [KEY_W-1:0]  key_q   [TABLE_DEPTH];
  logic [1:0]        phase_q [TABLE_DEPTH];
  logic [TIME_W-1:0] dl_q    [TABLE_DEPTH];

  logic [DELAY_W-1:0] delay_q;
  logic [2:0]         mode_q;
  logic [KEY_W-1:0]   item_key_q;
  logic [TIME_W-1:0]  now_q, arm_dl_q;
  logic [IDX_W-1:0]   idx_q, match_slot_q, free_slot_q, cand_slot_q;
  logic               match_q, free_q, cand_q, pend_q, have_prev_q;
  logic [KEY_W-1:0]   cand_key_q, pend_key_q, prev_key_q;

  logic [TIME_W:0]    dl_sum;
  logic [TIME_W-1:0]  dl_sat;
  logic               out_free, is_recon;
  logic               hit, eligible;
  logic [1:0]         match_res;
  logic [1:0]         list_state;

  assign dl_sum   = {1'b0, in_now_i} + (TIME_W+1)'(delay_q);
  assign dl_sat   = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
  assign out_free = !out_valid_o || out_ready_i;
  assign is_recon = (mode_q == MODE_RECONNECT);
  assign list_state = is_recon ? PH_AWAIT : PH_MUTE;

  assign hit = valid_q[idx_q] && (key_q[idx_q] == item_key_q);
  assign eligible = valid_q[idx_q] && (!have_prev_q || (key_q[idx_q] > prev_key_q)) &&
                    (is_recon || ((phase_q[idx_q] == PH_AWAIT) && (now_q > dl_q[idx_q]))) &&
                    (!cand_q || (key_q[idx_q] < cand_key_q));

  assign match_res = ((phase_q[match_slot_q] == PH_AWAIT) && (now_q > dl_q[match_slot_q])) ?
                     PH_MUTE : phase_q[match_slot_q];

  assign sts_o.scan_last  = (idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.cand_found = cand_q;
  assign sts_o.pend_valid = pend_q;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (cfg_we_i) begin
      delay_q <= (cfg_wdata_i < DELAY_W'(MIN_DELAY_MS)) ? DELAY_W'(MIN_DELAY_MS) : cfg_wdata_i;
    end
  end

  // item and search control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; match_q <= 1'b0; free_q <= 1'b0; cand_q <= 1'b0;
      pend_q <= 1'b0; have_prev_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0; match_q <= 1'b0; free_q <= 1'b0; cand_q <= 1'b0;
        pend_q <= 1'b0; have_prev_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (hit) match_q <= 1'b1;
        if (!valid_q[idx_q] && !free_q) free_q <= 1'b1;
        if (eligible) cand_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        idx_q  <= '0;
        cand_q <= 1'b0;
        if (cand_q) begin
          pend_q      <= 1'b1;
          have_prev_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= in_mode_i;
      item_key_q <= in_key_i;
      now_q      <= in_now_i;
      arm_dl_q   <= dl_sat;
    end
    if (cmd_i.scan_step) begin
      if (hit) match_slot_q <= idx_q;
      if (!valid_q[idx_q] && !free_q) free_slot_q <= idx_q;
      if (eligible) begin
        cand_key_q  <= key_q[idx_q];
        cand_slot_q <= idx_q;
      end
    end
    if (cmd_i.decide && cand_q) begin
      pend_key_q <= cand_key_q;
      prev_key_q <= cand_key_q;
    end
  end

  // entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) valid_q[i] <= 1'b0;
    end else if (cmd_i.act) begin
      if (mode_q == MODE_SUBSCRIBE && !match_q && free_q) valid_q[free_slot_q] <= 1'b1;
      if (mode_q == MODE_UNSUBSCRIBE && match_q) valid_q[match_slot_q] <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.act) begin
      if (mode_q == MODE_SUBSCRIBE && !match_q && free_q) begin
        key_q[free_slot_q]   <= item_key_q;
        phase_q[free_slot_q] <= PH_SUB;
        dl_q[free_slot_q]    <= '0;
      end
      if (mode_q == MODE_TICK && match_q) phase_q[match_slot_q] <= PH_LIVE;
    end
    if (cmd_i.decide && cand_q && is_recon) begin
      phase_q[cand_slot_q] <= PH_AWAIT;
      dl_q[cand_slot_q]    <= arm_dl_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.act || (cmd_i.decide && (pend_q || !cand_q))) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act) begin
      out_token_o <= item_key_q;
      out_found_o <= match_q;
      out_full_o  <= 1'b0;
      out_last_o  <= 1'b1;
      out_state_o <= PH_SUB;
      unique case (mode_q)
        MODE_SUBSCRIBE: begin
          if (match_q) out_state_o <= match_res;
          else out_full_o <= !free_q;
        end
        MODE_TICK:  if (match_q) out_state_o <= PH_LIVE;
        MODE_QUERY: if (match_q) out_state_o <= match_res;
        MODE_UNSUBSCRIBE: ;
        default: out_found_o <= 1'b0;
      endcase
    end else if (cmd_i.decide && (pend_q || !cand_q)) begin
      out_full_o  <= 1'b0;
      out_token_o <= pend_q ? pend_key_q : '0;
      out_state_o <= pend_q ? list_state : PH_SUB;
      out_found_o <= pend_q;
      out_last_o  <= !cand_q;
    end
  end

  assign out_tradable_o = (out_state_o == PH_LIVE);

endmodule
`default_nettype wire

@@ sv/feed_resubscribe_liveness_table_core.sv @@
// Top level of the feed resubscribe liveness table; joins controller and datapath.
// Depends on frlt_pkg, frlt_ctrl, frlt_dp.
//
// Input channel s_axis: tuser carries the mode, tdata the token key and the time.
// Output channel m_axis: one beat per result, tlast on the final beat of an item.
// One item is handled at a time; s_axis_tready is high only between items.
// Token ops (subscribe, unsubscribe, tick, query) walk the 32-entry table one entry
// per cycle. Unknown modes skip the walk and go straight to the result.
// Reconnect and mute list run one selection pass over the table per listed token,
// plus a final pass that finds none, to produce ascending key order.
// Results sit in an output register; a stalled receiver holds the beat and the
// walk pauses at the next result until the register frees up.
// Reset clears all entries and sets the first-tick delay to 1000 ms.
// cfg_we_i writes the delay (values below the minimum are raised); write only
// while idle.
`default_nettype none
module feed_resubscribe_liveness_table_core import frlt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // token_key[31:0], now_ms[79:32]
  input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // out_token[31:0], feed_state[33:32],
                                          // tradable[34], found[35], table_full[36]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  ctl_cmd_t         cmd;
  ctl_sts_t         sts;
  logic [KEY_W-1:0] out_token;
  logic [1:0]       out_state;
  logic             out_tradable, out_found, out_full;

  frlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frlt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_mode_i      (s_axis_tuser),
    .in_key_i       (s_axis_tdata[31:0]),
    .in_now_i       (s_axis_tdata[79:32]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_token_o    (out_token),
    .out_state_o    (out_state),
    .out_tradable_o (out_tradable),
    .out_found_o    (out_found),
    .out_full_o     (out_full),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_full, out_found, out_tradable, out_state, out_token};

endmodule
`default_nettype wire

@@ sv/frlt_checker.sv @@
// Port-level checks for feed_resubscribe_liveness_table_core, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module frlt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_full_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[36] |-> m_axis_tlast && !m_axis_tdata[35])
    else $error("table_full on a non-final or found beat");

  a_tradable_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34] == (m_axis_tdata[33:32] == 2'd2)))
    else $error("tradable does not match live state");

endmodule

bind feed_resubscribe_liveness_table_core frlt_checker u_frlt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ bench/feed_resubscribe_liveness_table_core_test.sv @@
// Self-checking bench for feed_resubscribe_liveness_table_core: a directed table,
// then fill/overflow runs and random traffic in all modes, each checked by a liveness predictor.
// Depends on frlt_pkg and the core RTL.
`default_nettype none
module feed_resubscribe_liveness_table_core_test;
  import frlt_pkg::*;

  typedef struct packed {
    logic [31:0] token;
    logic [1:0]  state;
    logic        tradable;
    logic        found;
    logic        full;
    logic        last;
  } feed_result_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [47:0] now;
    bit          has_want;
    feed_result_t want;
  } dir_row_t;

  localparam logic [2:0] MODE_BAD6 = 3'd6;
  localparam logic [2:0] MODE_BAD7 = 3'd7;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  feed_resubscribe_liveness_table_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  bit          tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_key   [TABLE_DEPTH];
  phase_e      tbl_phase [TABLE_DEPTH];
  logic [47:0] tbl_dl    [TABLE_DEPTH];
  logic [15:0] delay_ms = DELAY_RESET;

  feed_result_t expected_q[$];
  dir_row_t    rows[$];
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;
  logic [47:0] clock_ms = '0;

  initial forever #5 clk_i = ~clk_i;

  function automatic feed_result_t mk(logic [31:0] tok, phase_e st, bit fnd, bit full,
                                      bit lst);
    feed_result_t r;
    r.token = tok; r.state = st; r.tradable = (st == PH_LIVE); r.found = fnd;
    r.full = full; r.last = lst;
    return r;
  endfunction

  function automatic void expect_beat(feed_result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void add_row(logic [2:0] mode, logic [31:0] key, logic [47:0] now,
                                  bit has_want, feed_result_t want);
    dir_row_t r;
    r.mode = mode; r.key = key; r.now = now; r.has_want = has_want; r.want = want;
    rows.insert(rows.size(), r);
  endfunction

  function automatic phase_e live_state(int i, logic [47:0] now);
    if (tbl_phase[i] == PH_AWAIT && now > tbl_dl[i]) return PH_MUTE;
    return tbl_phase[i];
  endfunction

  // slots of valid entries, ascending key
  function automatic void ordered_slots(ref int idx[$]);
    int j;
    idx.delete();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_valid[i]) continue;
      j = 0;
      while (j < idx.size() && tbl_key[idx[j]] < tbl_key[i]) j++;
      idx.insert(j, i);
    end
  endfunction

  task automatic predict_liveness(logic [2:0] mode, logic [31:0] key, logic [47:0] now);
    int slot;
    int idx[$];
    int hits;
    logic [48:0] dl;
    feed_result_t r;
    slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
    case (mode)
      MODE_SUBSCRIBE: begin
        if (slot >= 0) expect_beat(mk(key, live_state(slot, now), 1, 0, 1));
        else begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && !tbl_valid[i]) begin
              slot = i; tbl_valid[i] = 1; tbl_key[i] = key;
              tbl_phase[i] = PH_SUB; tbl_dl[i] = '0;
            end
          expect_beat(mk(key, PH_SUB, 0, slot < 0, 1));
        end
      end
      MODE_UNSUBSCRIBE: begin
        if (slot >= 0) tbl_valid[slot] = 0;
        expect_beat(mk(key, PH_SUB, slot >= 0, 0, 1));
      end
      MODE_RECONNECT: begin
        dl = {1'b0, now} + delay_ms;
        if (dl > {1'b0, TIME_MAX}) dl = {1'b0, TIME_MAX};
        ordered_slots(idx);
        if (idx.size() == 0) expect_beat(mk('0, PH_SUB, 0, 0, 1));
        foreach (idx[k]) begin
          tbl_phase[idx[k]] = PH_AWAIT; tbl_dl[idx[k]] = dl[47:0];
          expect_beat(mk(tbl_key[idx[k]], PH_AWAIT, 1, 0, k == idx.size() - 1));
        end
      end
      MODE_TICK: begin
        if (slot >= 0) tbl_phase[slot] = PH_LIVE;
        expect_beat(mk(key, slot >= 0 ? PH_LIVE : PH_SUB, slot >= 0, 0, 1));
      end
      MODE_QUERY:
        expect_beat(mk(key, slot >= 0 ? live_state(slot, now) : PH_SUB,
                       slot >= 0, 0, 1));
      MODE_LIST_MUTE: begin
        ordered_slots(idx);
        hits = 0;
        foreach (idx[k])
          if (live_state(idx[k], now) == PH_MUTE) begin
            expect_beat(mk(tbl_key[idx[k]], PH_MUTE, 1, 0, 0));
            hits++;
          end
        if (hits == 0) expect_beat(mk('0, PH_SUB, 0, 0, 1));
        else begin
          r = expected_q.pop_back(); r.last = 1; expect_beat(r);
        end
      end
      default: expect_beat(mk(key, PH_SUB, 0, 0, 1));
    endcase
  endtask

  // one input beat; idles before it at random
  task automatic send_beat(logic [2:0] mode, logic [31:0] key, logic [47:0] now);
    while (!no_idle && $urandom_range(99) < 26) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {now, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_liveness(mode, key, now);
    s_axis_tvalid <= 1'b0;
    // core stays busy after taking a beat, so this costs no throughput
    @(posedge clk_i);
  endtask

  task automatic drain_and_settle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3 * (TABLE_DEPTH + 2)) @(posedge clk_i);
  endtask

  task automatic write_delay(logic [15:0] v);
    drain_and_settle();
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    delay_ms = (v < MIN_DELAY_MS) ? 16'(MIN_DELAY_MS) : v;
  endtask

  // receiver: random stall, compare each beat against the oldest expectation
  always @(posedge clk_i) begin
    feed_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk(m_axis_tdata[31:0], phase_e'(m_axis_tdata[33:32]), m_axis_tdata[35],
                 m_axis_tdata[36], m_axis_tlast);
        got.tradable = m_axis_tdata[34];
        if (expected_q.size() == 0) begin
          $error("unexpected result beat token=%h", got.token); errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.token !== want.token) begin
            $error("out_token exp %h got %h", want.token, got.token); errors++; end
          if (got.state !== want.state) begin
            $error("feed_state exp %0d got %0d", want.state, got.state); errors++; end
          if (got.tradable !== want.tradable) begin
            $error("tradable exp %0d got %0d", want.tradable, got.tradable); errors++; end
          if (got.found !== want.found) begin
            $error("found exp %0d got %0d", want.found, got.found); errors++; end
          if (got.full !== want.full) begin
            $error("table_full exp %0d got %0d", want.full, got.full); errors++; end
          if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++; end
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 26);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i)
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end

  function automatic logic [31:0] pick_key();
    // small pool so tokens collide; sometimes a fully random key
    if ($urandom_range(9) == 0) return $urandom;
    return {$urandom_range(1) ? 28'hFFFF_FFF : 28'h0, 4'($urandom_range(15))}
           ^ {4'($urandom_range(1) * 15), 28'h0};
  endfunction

  task automatic advance_time();
    case ($urandom_range(3))
      0: ;
      1: clock_ms = clock_ms + $urandom_range(3);
      2: clock_ms = clock_ms + delay_ms;
      default: clock_ms = clock_ms + $urandom_range(2 * delay_ms + 2);
    endcase
  endtask

  initial begin
    dir_row_t row;
    logic [2:0] m;
    int pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: mode, key, now, has_want, want
    add_row(MODE_QUERY, 32'hFFFF_FFFF, '0, 1, mk(32'hFFFF_FFFF, PH_SUB, 0, 0, 1));
    add_row(MODE_LIST_MUTE, '0, '0, 1, mk('0, PH_SUB, 0, 0, 1));
    add_row(MODE_RECONNECT, '0, '0, 1, mk('0, PH_SUB, 0, 0, 1));
    add_row(MODE_SUBSCRIBE, 32'h0, 48'd10, 1, mk(32'h0, PH_SUB, 0, 0, 1));
    add_row(MODE_SUBSCRIBE, 32'hFFFF_FFFF, 48'd10, 1, mk(32'hFFFF_FFFF, PH_SUB, 0, 0, 1));
    add_row(MODE_SUBSCRIBE, 32'h0, 48'd10, 1, mk(32'h0, PH_SUB, 1, 0, 1));
    add_row(MODE_RECONNECT, '0, 48'd100, 0, '0);
    add_row(MODE_QUERY, 32'h0, 48'd1100, 0, '0);
    add_row(MODE_QUERY, 32'h0, 48'd1101, 0, '0);
    add_row(MODE_TICK, 32'hFFFF_FFFF, 48'd1101, 1, mk(32'hFFFF_FFFF, PH_LIVE, 1, 0, 1));
    add_row(MODE_LIST_MUTE, '0, 48'd2000, 0, '0);
    add_row(MODE_TICK, 32'h1234, 48'd2000, 1, mk(32'h1234, PH_SUB, 0, 0, 1));
    add_row(MODE_BAD6, 32'hA5A5_5A5A, TIME_MAX, 1, mk(32'hA5A5_5A5A, PH_SUB, 0, 0, 1));
    add_row(MODE_BAD7, 32'h5A5A_A5A5, TIME_MAX, 1, mk(32'h5A5A_A5A5, PH_SUB, 0, 0, 1));
    add_row(MODE_UNSUBSCRIBE, 32'h0, 48'd2000, 1, mk(32'h0, PH_SUB, 1, 0, 1));
    add_row(MODE_UNSUBSCRIBE, 32'h0, 48'd2000, 1, mk(32'h0, PH_SUB, 0, 0, 1));
    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_want) begin
        send_beat(row.mode, row.key, row.now);
        if (expected_q[$] !== row.want) begin
          $error("directed row %0d: table expects %h, predictor %h", i, row.want,
                 expected_q[$]);
          errors++;
        end
      end else
        send_beat(row.mode, row.key, row.now);
    end

    // fill the table, overflow it, then saturating deadline near the top of time
    for (int i = 0; i <= TABLE_DEPTH; i++)
      send_beat(MODE_SUBSCRIBE, 32'h8000_0000 + i * 32'h0101_0101, 48'd3000);
    write_delay(16'hFFFF);
    send_beat(MODE_RECONNECT, '0, TIME_MAX - 48'd5);
    send_beat(MODE_LIST_MUTE, '0, TIME_MAX);
    for (int i = 0; i <= TABLE_DEPTH; i++)
      send_beat(MODE_UNSUBSCRIBE, 32'h8000_0000 + i * 32'h0101_0101, TIME_MAX);
    write_delay(16'h0000);
    write_delay(16'd1);

    // random phases, each starting with a delay write
    clock_ms = '0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_delay(16'd1);
        1: write_delay(16'd50);
        2: write_delay(16'hFFFF);
        3: write_delay(16'($urandom_range(1, 500)));
        default: write_delay(DELAY_RESET);
      endcase
      no_idle = (phase == 4);
      for (int n = 0; n < 64; n++) begin
        advance_time();
        if (clock_ms[47:40] != 0) clock_ms = '0;
        pick = $urandom_range(99);
        if (pick < 30) m = MODE_SUBSCRIBE;
        else if (pick < 42) m = MODE_UNSUBSCRIBE;
        else if (pick < 50) m = MODE_RECONNECT;
        else if (pick < 66) m = MODE_TICK;
        else if (pick < 84) m = MODE_QUERY;
        else if (pick < 96) m = MODE_LIST_MUTE;
        else m = 3'($urandom_range(6, 7));
        send_beat(m, pick_key(), clock_ms);
        if (n == 32) while (expected_q.size() != 0) @(posedge clk_i);
      end
      // occasional wide random time jump exercises all now bits
      send_beat(MODE_LIST_MUTE, '0, 48'({$urandom, $urandom}));
      send_beat(MODE_QUERY, $urandom, 48'({$urandom, $urandom}));
    end
    no_idle = 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * (TABLE_DEPTH + 2)) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
